// ===== design/sata_pkg.sv =====
// ----------------------------------------------------------------------------
// sata_pkg: shared types and constants
// Field widths, request and register codes, controller states and the
// divider result word for the sprite animation tile addresser.
// ----------------------------------------------------------------------------
package sata_pkg;

   localparam int REQ_TYPE_W   = 3;
   localparam int DELTA_W      = 16;
   localparam int TILE_W       = 12;
   localparam int ENTRY_W      = 4;
   localparam int SRC_X_W      = 12;
   localparam int SRC_Y_W      = 22;

   localparam int PERIOD_W     = 16;
   localparam int COUNT_W      = 5;
   localparam int TSIZE_W      = 11;
   localparam int SHEET_W      = 13;
   localparam int ELAPSED_W    = 17;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   localparam int DIV_W        = 13;
   localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

   localparam int MUL_STEPS    = 12;
   localparam int MUL_CNT_W    = $clog2(MUL_STEPS + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_TICK        = 3'd0,
      REQ_PLAY        = 3'd1,
      REQ_STOP        = 3'd2,
      REQ_SET_TILE    = 3'd3,
      REQ_WRITE_ENTRY = 3'd4
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_PERIOD = 3'd0,
      CSR_LOOP_ENABLE  = 3'd1,
      CSR_FRAME_COUNT  = 3'd2,
      CSR_TILE_WIDTH   = 3'd3,
      CSR_TILE_HEIGHT  = 3'd4,
      CSR_SHEET_WIDTH  = 3'd5
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIV_W,
      ST_DIV_T,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_result_type;

endpackage

// ===== design/sata_ifs.sv =====
// ----------------------------------------------------------------------------
// sata_ifs: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface sata_req_if;
   logic                             valid;
   logic                             ready;
   logic [sata_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [sata_pkg::DELTA_W-1:0]     delta;
   logic [sata_pkg::TILE_W-1:0]      tile_value;
   logic [sata_pkg::ENTRY_W-1:0]     entry;

   modport source (output valid, output req_type, output delta, output tile_value,
                   output entry, input ready);
   modport sink   (input valid, input req_type, input delta, input tile_value,
                   input entry, output ready);
endinterface

interface sata_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sata_pkg::TILE_W-1:0]   tile_index;
   logic [sata_pkg::SRC_X_W-1:0]  src_x;
   logic [sata_pkg::SRC_Y_W-1:0]  src_y;
   logic                          playing;

   modport source (output valid, output tile_index, output src_x, output src_y,
                   output playing, input ready);
   modport sink   (input valid, input tile_index, input src_x, input src_y,
                   input playing, output ready);
endinterface

// ===== design/sprite_animation_tile_addresser.sv =====
// ----------------------------------------------------------------------------
// sprite_animation_tile_addresser: sprite-sheet animation stepper
// Steps a frame-table animation on tick words and gives the shown tile's
// pixel origin on the sheet.
//
//   channel  dir  handshake          contents
//   req      in   valid/ready        req_type, delta, tile_value, entry
//   rsp      out  valid/ready        tile_index, src_x, src_y, playing
//   csr      in   csr_we, no wait    csr_index, csr_wdata
//
// One rsp word per req word. Each word passes through two 13-step serial
// divisions and a 12-step serial multiply; play, or a tick that advances the
// frame, first reads the frame table.
// A new req word is taken while the previous rsp word waits in its register.
// Synchronous reset; the frame table holds no reset value.
// ----------------------------------------------------------------------------
module sprite_animation_tile_addresser #(
   parameter int MAX_FRAMES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   sata_req_if.sink                          req,
   sata_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [sata_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sata_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FP_W  = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int TW    = sata_pkg::TILE_W;
   localparam int DW    = sata_pkg::DIV_W;
   localparam int YW    = sata_pkg::SRC_Y_W;
   localparam int XW    = sata_pkg::SRC_X_W;

   // configuration
   logic [sata_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                          loop_ff, loop_in;
   logic [sata_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [sata_pkg::TSIZE_W-1:0]  tile_w_ff, tile_w_in;
   logic [sata_pkg::TSIZE_W-1:0]  tile_h_ff, tile_h_in;
   logic [sata_pkg::SHEET_W-1:0]  sheet_w_ff, sheet_w_in;

   // animation state
   sata_pkg::state_type            state_ff, state_in;
   logic [sata_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [FP_W-1:0]                frame_pos_ff, frame_pos_in;
   logic                           running_ff, running_in;
   logic [TW-1:0]                  shown_tile_ff, shown_tile_in;

   // datapath
   logic [DW-1:0]                  per_row_ff, per_row_in;
   logic [TW-1:0]                  mcol_ff, mcol_in;
   logic [TW-1:0]                  mrow_ff, mrow_in;
   logic [XW-1:0]                  tw_sh_ff, tw_sh_in;
   logic [YW-1:0]                  th_sh_ff, th_sh_in;
   logic [XW-1:0]                  acc_x_ff, acc_x_in;
   logic [YW-1:0]                  acc_y_ff, acc_y_in;
   logic [sata_pkg::MUL_CNT_W-1:0] mcnt_ff, mcnt_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]                  rsp_tile_ff, rsp_tile_in;
   logic [XW-1:0]                  rsp_x_ff, rsp_x_in;
   logic [YW-1:0]                  rsp_y_ff, rsp_y_in;
   logic                           rsp_play_ff, rsp_play_in;

   logic                           req_accept;
   logic [CNT_W-1:0]               used_n;
   logic [DW-1:0]                  divw;
   logic [DW-1:0]                  per_row_q;

   logic                           ram_we;
   logic [FP_W-1:0]                ram_waddr;
   logic [FP_W-1:0]                ram_raddr;
   logic [TW-1:0]                  ram_rdata;

   logic                           div_start;
   logic [DW-1:0]                  div_dividend;
   logic [DW-1:0]                  div_divisor;
   sata_pkg::div_result_type       div_res;

   assign req.ready  = (state_ff == sata_pkg::ST_IDLE);
   assign req_accept = req.valid && req.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.tile_index = rsp_tile_ff;
   assign rsp.src_x      = rsp_x_ff;
   assign rsp.src_y      = rsp_y_ff;
   assign rsp.playing    = rsp_play_ff;

   assign used_n = (count_ff == '0) ? CNT_W'(1) :
                   (32'(count_ff) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) :
                   CNT_W'(count_ff);
   assign divw      = (tile_w_ff == '0) ? DW'(1) : DW'(tile_w_ff);
   assign per_row_q = (div_res.quotient == '0) ? DW'(1) : div_res.quotient;
   assign ram_waddr = FP_W'(req.entry);

   sata_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_FRAMES)
   ) u_frame_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.tile_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sata_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // register writes
   always_comb begin
      period_in  = period_ff;
      loop_in    = loop_ff;
      count_in   = count_ff;
      tile_w_in  = tile_w_ff;
      tile_h_in  = tile_h_ff;
      sheet_w_in = sheet_w_ff;
      if (csr_we) begin
         unique case (csr_index)
            sata_pkg::CSR_FRAME_PERIOD: period_in  = csr_wdata;
            sata_pkg::CSR_LOOP_ENABLE:  loop_in    = csr_wdata[0];
            sata_pkg::CSR_FRAME_COUNT:  count_in   = csr_wdata[sata_pkg::COUNT_W-1:0];
            sata_pkg::CSR_TILE_WIDTH:   tile_w_in  = csr_wdata[sata_pkg::TSIZE_W-1:0];
            sata_pkg::CSR_TILE_HEIGHT:  tile_h_in  = csr_wdata[sata_pkg::TSIZE_W-1:0];
            sata_pkg::CSR_SHEET_WIDTH:  sheet_w_in = csr_wdata[sata_pkg::SHEET_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      logic [sata_pkg::ELAPSED_W-1:0] sum;
      logic [CNT_W-1:0]               next_pos;
      logic                           fetch;

      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      frame_pos_in  = frame_pos_ff;
      running_in    = running_ff;
      shown_tile_in = shown_tile_ff;
      per_row_in    = per_row_ff;
      mcol_in       = mcol_ff;
      mrow_in       = mrow_ff;
      tw_sh_in      = tw_sh_ff;
      th_sh_in      = th_sh_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      mcnt_in       = mcnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_tile_in   = rsp_tile_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_play_in   = rsp_play_ff;
      ram_we        = 1'b0;
      ram_raddr     = '0;
      div_start     = 1'b0;
      div_dividend  = sheet_w_ff;
      div_divisor   = divw;
      fetch         = 1'b0;
      sum           = sata_pkg::ELAPSED_W'(elapsed_ff + sata_pkg::ELAPSED_W'(req.delta));
      next_pos      = CNT_W'(frame_pos_ff) + CNT_W'(1);

      unique case (state_ff)
         sata_pkg::ST_IDLE: begin
            if (req.valid) begin
               case (req.req_type)
                  sata_pkg::REQ_TICK: begin
                     if (running_ff) begin
                        if (sum >= sata_pkg::ELAPSED_W'(period_ff)) begin
                           elapsed_in = '0;
                           fetch      = 1'b1;
                           if (next_pos >= used_n) begin
                              if (loop_ff) begin
                                 frame_pos_in = '0;
                              end else begin
                                 running_in   = 1'b0;
                                 frame_pos_in = FP_W'(used_n - CNT_W'(1));
                              end
                           end else begin
                              frame_pos_in = FP_W'(next_pos);
                           end
                           ram_raddr = frame_pos_in;
                        end else begin
                           elapsed_in = sum;
                        end
                     end
                  end
                  sata_pkg::REQ_PLAY: begin
                     running_in   = 1'b1;
                     frame_pos_in = '0;
                     elapsed_in   = '0;
                     fetch        = 1'b1;
                  end
                  sata_pkg::REQ_STOP: begin
                     running_in = 1'b0;
                  end
                  sata_pkg::REQ_SET_TILE: begin
                     shown_tile_in = req.tile_value;
                  end
                  sata_pkg::REQ_WRITE_ENTRY: begin
                     ram_we = (32'(req.entry) < 32'(MAX_FRAMES));
                  end
                  default: ;
               endcase
               if (fetch) begin
                  state_in = sata_pkg::ST_FETCH;
               end else begin
                  state_in  = sata_pkg::ST_DIV_W;
                  div_start = 1'b1;
               end
            end
         end
         sata_pkg::ST_FETCH: begin
            shown_tile_in = ram_rdata;
            state_in      = sata_pkg::ST_DIV_W;
            div_start     = 1'b1;
         end
         sata_pkg::ST_DIV_W: begin
            if (div_res.done) begin
               per_row_in   = per_row_q;
               div_start    = 1'b1;
               div_dividend = DW'(shown_tile_ff);
               div_divisor  = per_row_q;
               state_in     = sata_pkg::ST_DIV_T;
            end
         end
         sata_pkg::ST_DIV_T: begin
            if (div_res.done) begin
               mrow_in  = div_res.quotient[TW-1:0];
               mcol_in  = div_res.remainder[TW-1:0];
               tw_sh_in = XW'(tile_w_ff);
               th_sh_in = YW'(tile_h_ff);
               acc_x_in = '0;
               acc_y_in = '0;
               mcnt_in  = sata_pkg::MUL_CNT_W'(sata_pkg::MUL_STEPS);
               state_in = sata_pkg::ST_MUL;
            end
         end
         sata_pkg::ST_MUL: begin
            acc_x_in = acc_x_ff + (mcol_ff[0] ? tw_sh_ff : XW'(0));
            acc_y_in = acc_y_ff + (mrow_ff[0] ? th_sh_ff : YW'(0));
            mcol_in  = mcol_ff >> 1;
            mrow_in  = mrow_ff >> 1;
            tw_sh_in = tw_sh_ff << 1;
            th_sh_in = th_sh_ff << 1;
            mcnt_in  = mcnt_ff - sata_pkg::MUL_CNT_W'(1);
            if (mcnt_ff == sata_pkg::MUL_CNT_W'(1)) begin
               state_in = sata_pkg::ST_OUT;
            end
         end
         sata_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_tile_in  = shown_tile_ff;
               rsp_x_in     = acc_x_ff;
               rsp_y_in     = acc_y_ff;
               rsp_play_in  = running_ff;
               state_in     = sata_pkg::ST_IDLE;
            end
         end
         default: state_in = sata_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= sata_pkg::PERIOD_W'(100);
         loop_ff       <= 1'b1;
         count_ff      <= sata_pkg::COUNT_W'(1);
         tile_w_ff     <= sata_pkg::TSIZE_W'(16);
         tile_h_ff     <= sata_pkg::TSIZE_W'(16);
         sheet_w_ff    <= sata_pkg::SHEET_W'(256);
         state_ff      <= sata_pkg::ST_IDLE;
         elapsed_ff    <= '0;
         frame_pos_ff  <= '0;
         running_ff    <= 1'b0;
         shown_tile_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         loop_ff       <= loop_in;
         count_ff      <= count_in;
         tile_w_ff     <= tile_w_in;
         tile_h_ff     <= tile_h_in;
         sheet_w_ff    <= sheet_w_in;
         state_ff      <= state_in;
         elapsed_ff    <= elapsed_in;
         frame_pos_ff  <= frame_pos_in;
         running_ff    <= running_in;
         shown_tile_ff <= shown_tile_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      per_row_ff  <= per_row_in;
      mcol_ff     <= mcol_in;
      mrow_ff     <= mrow_in;
      tw_sh_ff    <= tw_sh_in;
      th_sh_ff    <= th_sh_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      mcnt_ff     <= mcnt_in;
      rsp_tile_ff <= rsp_tile_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_play_ff <= rsp_play_in;
   end

   // column must come out below tiles per row
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sata_pkg::ST_DIV_T && div_res.done) |->
         (div_res.remainder < per_row_ff))
      else $error("column not below tiles per row");

   a_stop_cause: assert property (@(posedge clock)
      $fell(running_ff) |-> $past(req_accept || reset))
      else $error("playing dropped without a request word");

   a_frame_cause: assert property (@(posedge clock) disable iff (reset)
      (frame_pos_ff != $past(frame_pos_ff)) |-> $past(req_accept || reset))
      else $error("frame moved without a request word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sata_pkg::ST_OUT))
      else $error("response word raised outside output state");

endmodule

// ===== design/sata_ram.sv =====
// ----------------------------------------------------------------------------
// sata_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sata_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/sata_div.sv =====
// ----------------------------------------------------------------------------
// sata_div: bit-serial restoring divider
// One quotient bit per cycle; done is high for one cycle after the last step.
// ----------------------------------------------------------------------------
module sata_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sata_pkg::DIV_W-1:0]     dividend,
   input  logic [sata_pkg::DIV_W-1:0]     divisor,
   output sata_pkg::div_result_type       result
);

   localparam int W = sata_pkg::DIV_W;

   logic                            busy_ff, busy_in;
   logic [sata_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    dsr_ff, dsr_in;
   logic [W:0]                      trial;
   logic [W+1:0]                    diff;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = sata_pkg::DIV_CNT_W'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - sata_pkg::DIV_CNT_W'(1);
            rem_in = diff[W+1] ? trial[W-1:0] : diff[W-1:0];
            quo_in = {quo_ff[W-2:0], ~diff[W+1]};
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign result.done      = busy_ff && (cnt_ff == '0);
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: sprite animation tile addresser
// Drives request words through the valid/ready channel with random gaps and
// response back-pressure, including two long holds that back the block up.
// A tracker predicts the tile, source origin and playing flag for every
// accepted word and checks each response in order. Register settings change
// between phases, covering zero, contract limits and full field widths.
// ----------------------------------------------------------------------------
localparam int FRAME_SLOTS = 16;

typedef struct packed {
   logic [sata_pkg::TILE_W-1:0]  tile_index;
   logic [sata_pkg::SRC_X_W-1:0] src_x;
   logic [sata_pkg::SRC_Y_W-1:0] src_y;
   logic                         playing;
} tile_origin_type;

class tile_origin_tracker_type;
   logic [sata_pkg::PERIOD_W-1:0]  period    = 16'd100;
   logic                           loop_on   = 1'b1;
   logic [sata_pkg::COUNT_W-1:0]   count_reg = 5'd1;
   logic [sata_pkg::TSIZE_W-1:0]   tw        = 11'd16;
   logic [sata_pkg::TSIZE_W-1:0]   th        = 11'd16;
   logic [sata_pkg::SHEET_W-1:0]   sw        = 13'd256;
   logic [sata_pkg::ELAPSED_W-1:0] elapsed   = '0;
   logic [3:0]                     frame_pos = '0;
   logic                           running   = 1'b0;
   logic [sata_pkg::TILE_W-1:0]    shown     = '0;
   logic [sata_pkg::TILE_W-1:0]    frames [FRAME_SLOTS];
   tile_origin_type                origins_due [$];
   int unsigned                    errors    = 0;

   function void write_register(sata_pkg::csr_addr_type idx,
                                logic [sata_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         sata_pkg::CSR_FRAME_PERIOD: period = value;
         sata_pkg::CSR_LOOP_ENABLE:  loop_on = value[0];
         sata_pkg::CSR_FRAME_COUNT:  count_reg = value[sata_pkg::COUNT_W-1:0];
         sata_pkg::CSR_TILE_WIDTH:   tw = value[sata_pkg::TSIZE_W-1:0];
         sata_pkg::CSR_TILE_HEIGHT:  th = value[sata_pkg::TSIZE_W-1:0];
         sata_pkg::CSR_SHEET_WIDTH:  sw = value[sata_pkg::SHEET_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return origins_due.size();
   endfunction

   function void take_request(logic [sata_pkg::REQ_TYPE_W-1:0] kind,
                              logic [sata_pkg::DELTA_W-1:0] delta,
                              logic [sata_pkg::TILE_W-1:0] tval,
                              logic [sata_pkg::ENTRY_W-1:0] slot);
      int unsigned     used, next, divw, per_row, row, col;
      logic [31:0]     prod_x, prod_y;
      tile_origin_type w;
      case (kind)
         sata_pkg::REQ_TICK: begin
            if (running) begin
               elapsed = elapsed + delta;
               if (elapsed >= period) begin
                  elapsed = '0;
                  used = (count_reg == 0) ? 1 :
                         (count_reg > FRAME_SLOTS) ? FRAME_SLOTS : count_reg;
                  next = frame_pos + 1;
                  if (next >= used) begin
                     if (loop_on) begin
                        next = 0;
                     end else begin
                        running = 1'b0;
                        next = used - 1;
                     end
                  end
                  frame_pos = next[3:0];
                  shown = frames[frame_pos];
               end
            end
         end
         sata_pkg::REQ_PLAY: begin
            running = 1'b1;
            frame_pos = '0;
            elapsed = '0;
            shown = frames[0];
         end
         sata_pkg::REQ_STOP:        running = 1'b0;
         sata_pkg::REQ_SET_TILE:    shown = tval;
         sata_pkg::REQ_WRITE_ENTRY: frames[slot] = tval;
         default: ;
      endcase
      // tiles per row never drops below one, even for zero sizes
      divw = (tw == 0) ? 1 : tw;
      per_row = sw / divw;
      if (per_row == 0) per_row = 1;
      row = shown / per_row;
      col = shown % per_row;
      prod_x = col * tw;
      prod_y = row * th;
      w.tile_index = shown;
      w.src_x = prod_x[sata_pkg::SRC_X_W-1:0];
      w.src_y = prod_y[sata_pkg::SRC_Y_W-1:0];
      w.playing = running;
      origins_due = {origins_due, w};
   endfunction

   function void match_response(tile_origin_type got);
      tile_origin_type want;
      if (origins_due.size() == 0) begin
         $display("%0t: unexpected word: tile %0d x %0d y %0d playing %0b", $time,
                  got.tile_index, got.src_x, got.src_y, got.playing);
         errors++;
         return;
      end
      want = origins_due.pop_front();
      if (got.tile_index !== want.tile_index) begin
         $display("%0t: tile_index expected %0d actual %0d", $time,
                  want.tile_index, got.tile_index);
         errors++;
      end
      if (got.src_x !== want.src_x) begin
         $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, got.src_x);
         errors++;
      end
      if (got.src_y !== want.src_y) begin
         $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, got.src_y);
         errors++;
      end
      if (got.playing !== want.playing) begin
         $display("%0t: playing expected %0b actual %0b", $time, want.playing, got.playing);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int LONG_HOLD        = 500;
   localparam int RANDOM_PHASES    = 9;
   localparam int PHASE_WORDS      = 125;
   localparam int DRAIN_CYCLES     = 100;
   localparam int FIRST_UNUSED_REQ = 5;
   localparam int LAST_UNUSED_REQ  = 7;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_we;
   logic [sata_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sata_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                             calm = 1'b0;
   int unsigned                      cycle_count = 0;
   int unsigned                      cur_period = 100;
   tile_origin_tracker_type          tracker;

   sata_req_if req_ch();
   sata_rsp_if rsp_ch();

   sprite_animation_tile_addresser #(.MAX_FRAMES(FRAME_SLOTS)) i_dut (
      .clock,
      .reset,
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sprite_animation_tile_addresser] ERROR");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [sata_pkg::DELTA_W-1:0] any_delta();
      return sata_pkg::DELTA_W'($urandom);
   endfunction

   function automatic logic [sata_pkg::TILE_W-1:0] any_tile();
      return sata_pkg::TILE_W'($urandom);
   endfunction

   function automatic logic [sata_pkg::ENTRY_W-1:0] any_slot();
      return sata_pkg::ENTRY_W'($urandom);
   endfunction

   function automatic logic [sata_pkg::TILE_W-1:0] pick_tile();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return any_tile();
   endfunction

   function automatic logic [sata_pkg::DELTA_W-1:0] pick_delta();
      int unsigned r, lim;
      r = $urandom_range(0, 9);
      lim = (cur_period * 2 + 1 > 65535) ? 65535 : cur_period * 2 + 1;
      if (r < 6) return sata_pkg::DELTA_W'($urandom_range(0, lim));
      if (r < 8) begin
         return (cur_period > 0) ? sata_pkg::DELTA_W'(cur_period - $urandom_range(0, 1))
                                 : '0;
      end
      return any_delta();
   endfunction

   task automatic send_word(logic [sata_pkg::REQ_TYPE_W-1:0] kind,
                            logic [sata_pkg::DELTA_W-1:0] delta,
                            logic [sata_pkg::TILE_W-1:0] tval,
                            logic [sata_pkg::ENTRY_W-1:0] slot);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.delta      <= delta;
      req_ch.tile_value <= tval;
      req_ch.entry      <= slot;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.take_request(kind, delta, tval, slot);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic csr_write(sata_pkg::csr_addr_type idx,
                            logic [sata_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(idx, value);
   endtask

   task automatic configure(int unsigned period, int unsigned loopv, int unsigned count,
                            int unsigned tw, int unsigned th, int unsigned sw);
      int unsigned hi;
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      // junk above the register width must be dropped
      hi = $urandom_range(0, 1) ? $urandom : 0;
      csr_write(sata_pkg::CSR_FRAME_PERIOD, sata_pkg::CSR_DATA_W'(period));
      csr_write(sata_pkg::CSR_LOOP_ENABLE, sata_pkg::CSR_DATA_W'(loopv | (hi << 1)));
      csr_write(sata_pkg::CSR_FRAME_COUNT,
                sata_pkg::CSR_DATA_W'(count | (hi << sata_pkg::COUNT_W)));
      csr_write(sata_pkg::CSR_TILE_WIDTH,
                sata_pkg::CSR_DATA_W'(tw | (hi << sata_pkg::TSIZE_W)));
      csr_write(sata_pkg::CSR_TILE_HEIGHT,
                sata_pkg::CSR_DATA_W'(th | (hi << sata_pkg::TSIZE_W)));
      csr_write(sata_pkg::CSR_SHEET_WIDTH,
                sata_pkg::CSR_DATA_W'(sw | (hi << sata_pkg::SHEET_W)));
      csr_we <= 1'b0;
      cur_period = period & 16'hFFFF;
   endtask

   initial begin : response_side
      int unsigned     stall_left;
      int unsigned     words_seen;
      logic            took;
      tile_origin_type got;
      stall_left = 0;
      words_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         took = !reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
         if (took) begin
            got.tile_index = rsp_ch.tile_index;
            got.src_x = rsp_ch.src_x;
            got.src_y = rsp_ch.src_y;
            got.playing = rsp_ch.playing;
            tracker.match_response(got);
            words_seen++;
         end
         if (stall_left == 0) begin
            if (took && (words_seen == 80 || words_seen == 700)) begin
               stall_left = LONG_HOLD;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : request_side
      int i;
      int unsigned r;
      logic [sata_pkg::REQ_TYPE_W-1:0] odd_kind;
      logic [sata_pkg::TILE_W-1:0] tv;
      tracker = new;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= sata_pkg::CSR_FRAME_PERIOD;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= sata_pkg::REQ_TICK;
      req_ch.delta <= '0;
      req_ch.tile_value <= '0;
      req_ch.entry <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: stopped tick, tile extremes, fill the whole frame table
      send_word(sata_pkg::REQ_TICK, 16'd100, pick_tile(), any_slot());
      send_word(sata_pkg::REQ_SET_TILE, any_delta(), '1, any_slot());
      send_word(sata_pkg::REQ_SET_TILE, any_delta(), '0, any_slot());
      for (i = 0; i < FRAME_SLOTS; i++) begin
         tv = (i == 0) ? '1 : (i == 1) ? '0 : pick_tile();
         send_word(sata_pkg::REQ_WRITE_ENTRY, any_delta(), tv, sata_pkg::ENTRY_W'(i));
      end
      odd_kind = sata_pkg::REQ_TYPE_W'($urandom_range(FIRST_UNUSED_REQ, LAST_UNUSED_REQ));
      send_word(odd_kind, any_delta(), any_tile(), any_slot());
      send_word(sata_pkg::REQ_PLAY, any_delta(), any_tile(), any_slot());
      send_word(sata_pkg::REQ_TICK, '0, any_tile(), any_slot());
      send_word(sata_pkg::REQ_TICK, '1, any_tile(), any_slot());
      send_word(sata_pkg::REQ_STOP, any_delta(), any_tile(), any_slot());
      send_word(sata_pkg::REQ_TICK, '1, any_tile(), any_slot());

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(0, 0, 0, 0, 0, 0);
            1: configure(16'hFFFF, 1, 31, 2047, 2047, 8191);
            2: configure(1, 1, 16, 1, 1, 4096);
            3: configure(65535, 0, 1, 1024, 1024, 1);
            default: configure($urandom_range(1, 400), $urandom_range(0, 1),
                               $urandom_range(1, 16), $urandom_range(1, 64),
                               $urandom_range(1, 64), $urandom_range(16, 4096));
         endcase
         calm = (phase % 3 == 1);
         if ($urandom_range(0, 1)) begin
            send_word(sata_pkg::REQ_PLAY, any_delta(), any_tile(), any_slot());
         end
         repeat (PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
               send_word(sata_pkg::REQ_TICK, pick_delta(), any_tile(), any_slot());
            end else if (r < 70) begin
               send_word(sata_pkg::REQ_PLAY, any_delta(), any_tile(), any_slot());
            end else if (r < 75) begin
               send_word(sata_pkg::REQ_STOP, any_delta(), any_tile(), any_slot());
            end else if (r < 85) begin
               send_word(sata_pkg::REQ_SET_TILE, any_delta(), pick_tile(), any_slot());
            end else if (r < 96) begin
               send_word(sata_pkg::REQ_WRITE_ENTRY, any_delta(), pick_tile(), any_slot());
            end else begin
               odd_kind = sata_pkg::REQ_TYPE_W'($urandom_range(FIRST_UNUSED_REQ,
                                                               LAST_UNUSED_REQ));
               send_word(odd_kind, any_delta(), any_tile(), any_slot());
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("[sprite_animation_tile_addresser] OK");
      end else begin
         $display("[sprite_animation_tile_addresser] ERROR");
      end
      $finish;
   end
endmodule
